>>> rtl/core/fqpp_pkg.sv
`default_nettype none
package fqpp_pkg;

	localparam logic [7:0] CHR_PCT = 8'h25;
	localparam logic [7:0] CHR_AMP = 8'h26;
	localparam logic [7:0] CHR_EQ  = 8'h3D;
	localparam logic [7:0] CHR_NINE = 8'h39;
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_LOW_A = 8'h61;
	localparam logic [7:0] CHR_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;
	localparam logic [7:0] ALPHA_OFS = 8'h37;
	localparam logic [7:0] SIGN_BIT_VAL = 8'h80;

	typedef enum logic [1:0] {
		KIND_DATA      = 2'd0,
		KIND_NAME_END  = 2'd1,
		KIND_PAIR_END  = 2'd2,
		KIND_INPUT_END = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2,
		ESC_SPARE = 2'd3
	} esc_t;

	typedef struct packed {
		logic [1:0] lit_cnt;
		logic [7:0] held;
		logic [7:0] fin_byte;
		kind_t      fin_kind;
		logic       in_value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [7:0] digit_value(input logic [7:0] b);
		logic [7:0] u;
		u = b;
		if (b < SIGN_BIT_VAL && b > CHR_NINE) begin
			if (b >= CHR_LOW_A && b <= CHR_LOW_Z) begin
				u = b - CASE_GAP;
			end
			return u - ALPHA_OFS;
		end
		return b - CHR_ZERO;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/form_query_pair_parser_unit.sv
// out_valid for an item's first result rises after its command passes the queue into the
// output register. Items are taken one per cycle while the queue is not full; the output
// stage emits one result per cycle if out_ready; broken escapes give two or three results.
// A command queue of QUEUE_DEPTH entries lets the input side run on while output stalls.
// Reset: asynchronous, clears parse state, empties the queue and drops out_valid.
`default_nettype none
module form_query_pair_parser_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       is_end,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [1:0]      kind,
	output logic            in_value,
	output logic            last_of_run
);

	fqpp_pkg::cmd_t   cmd;
	fqpp_pkg::cmd_t   head;
	fqpp_pkg::qstat_t stat;
	logic             push;
	logic             pop;
	logic             accept;

	assign in_ready = !stat.full;
	assign accept   = in_valid && in_ready;

	fqpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.is_end    (is_end),
		.push      (push),
		.cmd       (cmd)
	);

	fqpp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	fqpp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.kind        (kind),
		.in_value    (in_value),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

>>> rtl/core/fqpp_front.sv
`default_nettype none
module fqpp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    data_byte,
	input  wire logic          is_end,
	output logic               push,
	output fqpp_pkg::cmd_t     cmd
);

	logic                value_mode_q;
	fqpp_pkg::esc_t      fill_q;
	logic [7:0]          held_q;

	logic                value_mode_d;
	fqpp_pkg::esc_t      fill_d;
	logic [7:0]          held_d;
	logic                has_cmd;
	logic                is_amp;
	logic                is_name_end;
	logic [7:0]          dec;

	assign is_amp      = data_byte == fqpp_pkg::CHR_AMP;
	assign is_name_end = data_byte == fqpp_pkg::CHR_EQ && !value_mode_q;
	assign dec = (fqpp_pkg::digit_value(held_q) << 4) | fqpp_pkg::digit_value(data_byte);

	always_comb begin
		value_mode_d  = value_mode_q;
		fill_d        = fill_q;
		held_d        = held_q;
		has_cmd       = 1'b0;
		cmd.lit_cnt   = 2'd0;
		cmd.held      = held_q;
		cmd.fin_byte  = 8'd0;
		cmd.fin_kind  = fqpp_pkg::KIND_DATA;
		cmd.in_value  = value_mode_q;
		if (is_end || is_amp || is_name_end) begin
			has_cmd     = 1'b1;
			cmd.lit_cnt = fill_q[1] ? 2'd2 : fill_q;
			if (is_end) begin
				cmd.fin_kind = fqpp_pkg::KIND_INPUT_END;
			end else if (is_amp) begin
				cmd.fin_kind = fqpp_pkg::KIND_PAIR_END;
			end else begin
				cmd.fin_kind = fqpp_pkg::KIND_NAME_END;
			end
			value_mode_d = !is_end && !is_amp;
			fill_d       = fqpp_pkg::ESC_NONE;
			held_d       = 8'd0;
		end else begin
			unique case (fill_q)
				fqpp_pkg::ESC_NONE: begin
					if (data_byte == fqpp_pkg::CHR_PCT) begin
						fill_d = fqpp_pkg::ESC_PCT;
					end else begin
						has_cmd      = 1'b1;
						cmd.fin_byte = data_byte;
					end
				end
				fqpp_pkg::ESC_PCT: begin
					held_d = data_byte;
					fill_d = fqpp_pkg::ESC_DIGIT;
				end
				default: begin
					has_cmd      = 1'b1;
					cmd.fin_byte = dec;
					fill_d       = fqpp_pkg::ESC_NONE;
					held_d       = 8'd0;
				end
			endcase
		end
	end

	assign push = accept && has_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_mode_q <= 1'b0;
			fill_q       <= fqpp_pkg::ESC_NONE;
			held_q       <= 8'd0;
		end else if (accept) begin
			value_mode_q <= value_mode_d;
			fill_q       <= fill_d;
			held_q       <= held_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/fqpp_queue.sv
`default_nettype none
module fqpp_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire fqpp_pkg::cmd_t wr_cmd,
	input  wire logic           pop,
	output fqpp_pkg::cmd_t      head,
	output fqpp_pkg::qstat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fqpp_pkg::cmd_t      mem_q [DEPTH];
	logic [PTR_W-1:0]    wptr_q;
	logic [PTR_W-1:0]    rptr_q;
	logic [CNT_W-1:0]    count_q;

	assign head       = mem_q[rptr_q];
	assign stat.full  = count_q == CNT_W'(DEPTH);
	assign stat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/fqpp_back.sv
`default_nettype none
module fqpp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fqpp_pkg::cmd_t   head,
	input  wire fqpp_pkg::qstat_t stat,
	output logic                  pop,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic [7:0]            out_byte,
	output logic [1:0]            kind,
	output logic                  in_value,
	output logic                  last_of_run
);

	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic [1:0]  kind_q;
	logic        in_value_q;
	logic        last_q;
	logic [1:0]  step_q;

	logic        load;
	logic        is_lit;
	logic [7:0]  sel_byte;
	logic [1:0]  sel_kind;

	assign load   = !out_valid_q || out_ready;
	assign is_lit = step_q < head.lit_cnt;
	assign pop    = load && !stat.empty && !is_lit;

	always_comb begin
		if (is_lit) begin
			sel_byte = (step_q == 2'd0) ? fqpp_pkg::CHR_PCT : head.held;
			sel_kind = fqpp_pkg::KIND_DATA;
		end else begin
			sel_byte = head.fin_byte;
			sel_kind = head.fin_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !stat.empty) begin
			byte_q     <= sel_byte;
			kind_q     <= sel_kind;
			in_value_q <= head.in_value;
			last_q     <= !is_lit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 2'd0;
		end else if (load) begin
			out_valid_q <= !stat.empty;
			if (!stat.empty) begin
				step_q <= is_lit ? step_q + 2'd1 : 2'd0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign kind        = kind_q;
	assign in_value    = in_value_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none
module tb;

	typedef struct packed {
		logic [7:0]       ch;
		fqpp_pkg::kind_t  knd;
		logic             val;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       typed;
		logic [1:0] n;
		res_t       t0;
		res_t       t1;
		res_t       t2;
	} stim_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       is_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       in_value;
	logic       last_of_run;

	stim_t stim_q [$];
	res_t  pending_res [$];
	res_t  step_res [$];

	logic           pv_value;
	fqpp_pkg::esc_t pv_fill;
	logic [7:0]     pv_held;

	bit hold_req;
	bit calm;
	int bad;
	int n_items;
	int n_results;
	int n_in_stall;

	form_query_pair_parser_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.is_end     (is_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.in_value   (in_value),
		.last_of_run(last_of_run)
	);

	function automatic res_t mk_res(input logic [7:0] c, input fqpp_pkg::kind_t k,
			input logic v, input logic l);
		res_t r;
		r.ch = c;
		r.knd = k;
		r.val = v;
		r.last = l;
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [7:0] b);
		logic [7:0] u;
		u = b;
		if (b[7] == 1'b0 && b > fqpp_pkg::CHR_NINE) begin
			if (b >= fqpp_pkg::CHR_LOW_A && b <= fqpp_pkg::CHR_LOW_Z) begin
				u = b - fqpp_pkg::CASE_GAP;
			end
			return u - fqpp_pkg::ALPHA_OFS;
		end
		return b - fqpp_pkg::CHR_ZERO;
	endfunction

	function automatic void decode_item(input logic [7:0] b, input logic e);
		res_t r [3];
		int n;
		logic [7:0] dec;
		n = 0;
		step_res.delete();
		if (e || b == fqpp_pkg::CHR_AMP || (b == fqpp_pkg::CHR_EQ && !pv_value)) begin
			if (pv_fill != fqpp_pkg::ESC_NONE) begin
				r[n] = mk_res(fqpp_pkg::CHR_PCT, fqpp_pkg::KIND_DATA, pv_value, 1'b0);
				n++;
			end
			if (pv_fill == fqpp_pkg::ESC_DIGIT || pv_fill == fqpp_pkg::ESC_SPARE) begin
				r[n] = mk_res(pv_held, fqpp_pkg::KIND_DATA, pv_value, 1'b0);
				n++;
			end
			pv_fill = fqpp_pkg::ESC_NONE;
			pv_held = 8'h00;
			if (e) begin
				r[n] = mk_res(8'h00, fqpp_pkg::KIND_INPUT_END, pv_value, 1'b0);
				pv_value = 1'b0;
			end else if (b == fqpp_pkg::CHR_AMP) begin
				r[n] = mk_res(8'h00, fqpp_pkg::KIND_PAIR_END, pv_value, 1'b0);
				pv_value = 1'b0;
			end else begin
				r[n] = mk_res(8'h00, fqpp_pkg::KIND_NAME_END, 1'b0, 1'b0);
				pv_value = 1'b1;
			end
			n++;
		end else if (pv_fill == fqpp_pkg::ESC_NONE) begin
			if (b == fqpp_pkg::CHR_PCT) begin
				pv_fill = fqpp_pkg::ESC_PCT;
			end else begin
				r[n] = mk_res(b, fqpp_pkg::KIND_DATA, pv_value, 1'b0);
				n++;
			end
		end else if (pv_fill == fqpp_pkg::ESC_PCT) begin
			pv_held = b;
			pv_fill = fqpp_pkg::ESC_DIGIT;
		end else begin
			dec = (hex_digit(pv_held) << 4) | hex_digit(b);
			r[n] = mk_res(dec, fqpp_pkg::KIND_DATA, pv_value, 1'b0);
			n++;
			pv_fill = fqpp_pkg::ESC_NONE;
			pv_held = 8'h00;
		end
		for (int i = 0; i < n; i++) begin
			if (i == n - 1) begin
				r[i].last = 1'b1;
			end
			step_res.push_back(r[i]);
		end
	endfunction

	function automatic void push_item(input logic [7:0] c, input logic e);
		stim_t s;
		s = '0;
		s.ch = c;
		s.fin = e;
		stim_q.push_back(s);
	endfunction

	function automatic void push_typed(input logic [7:0] c, input logic e, input int n,
			input res_t a, input res_t b, input res_t d);
		stim_t s;
		s.ch = c;
		s.fin = e;
		s.typed = 1'b1;
		s.n = 2'(n);
		s.t0 = a;
		s.t1 = b;
		s.t2 = d;
		stim_q.push_back(s);
	endfunction

	function automatic logic [7:0] rand_hex();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) begin
			return 8'(fqpp_pkg::CHR_ZERO + v);
		end
		return 8'(($urandom_range(0, 1) ? fqpp_pkg::CHR_LOW_A : 8'h41) + v - 10);
	endfunction

	function automatic void push_token();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			case ($urandom_range(0, 2))
				0: push_item(8'(fqpp_pkg::CHR_LOW_A + $urandom_range(0, 25)), 1'b0);
				1: push_item(8'(8'h41 + $urandom_range(0, 25)), 1'b0);
				default: push_item(8'(fqpp_pkg::CHR_ZERO + $urandom_range(0, 9)), 1'b0);
			endcase
		end else if (pick < 82) begin
			push_item(fqpp_pkg::CHR_PCT, 1'b0);
			push_item(rand_hex(), 1'b0);
			push_item(rand_hex(), 1'b0);
		end else if (pick < 90) begin
			push_item(fqpp_pkg::CHR_PCT, 1'b0);
			if ($urandom_range(0, 1)) begin
				push_item(rand_hex(), 1'b0);
			end
		end else begin
			push_item(8'($urandom_range(1, 255)), 1'b0);
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_ready) begin
			n_in_stall++;
		end
		if (arst_n && out_valid && out_ready) begin
			res_t got;
			res_t want;
			got = {out_byte, kind, in_value, last_of_run};
			n_results++;
			if (pending_res.size() == 0) begin
				if (bad < 10) begin
					$display("unexpected result: byte %h kind %0d val %b last %b",
						out_byte, kind, in_value, last_of_run);
				end
				bad++;
			end else begin
				want = pending_res.pop_front();
				if (got !== want) begin
					if (bad < 10) begin
						$display("mismatch: byte %h/%h kind %0d/%0d val %b/%b last %b/%b",
							want.ch, got.ch, want.knd, got.knd, want.val, got.val,
							want.last, got.last);
					end
					bad++;
				end
			end
		end
	end

	initial begin
		int gap;
		gap = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_req = 1'b0;
			end else if (gap > 0 && !calm) begin
				out_ready <= 1'b0;
				gap--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		stim_t it;
		int n_dir;
		int total;
		res_t z;
		z = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		is_end = 1'b0;
		hold_req = 1'b0;
		calm = 1'b0;
		bad = 0;
		n_items = 0;
		n_results = 0;
		n_in_stall = 0;
		pv_value = 1'b0;
		pv_fill = fqpp_pkg::ESC_NONE;
		pv_held = 8'h00;

		push_typed(8'h61, 1'b0, 1, mk_res(8'h61, fqpp_pkg::KIND_DATA, 1'b0, 1'b1), z, z);
		push_typed(fqpp_pkg::CHR_EQ, 1'b0, 1,
			mk_res(8'h00, fqpp_pkg::KIND_NAME_END, 1'b0, 1'b1), z, z);
		push_typed(fqpp_pkg::CHR_PCT, 1'b0, 0, z, z, z);
		push_typed(8'h34, 1'b0, 0, z, z, z);
		push_typed(8'h31, 1'b0, 1, mk_res(8'h41, fqpp_pkg::KIND_DATA, 1'b1, 1'b1), z, z);
		push_typed(fqpp_pkg::CHR_PCT, 1'b0, 0, z, z, z);
		push_typed(8'h66, 1'b0, 0, z, z, z);
		push_typed(8'h46, 1'b0, 1, mk_res(8'hFF, fqpp_pkg::KIND_DATA, 1'b1, 1'b1), z, z);
		push_typed(fqpp_pkg::CHR_EQ, 1'b0, 1,
			mk_res(fqpp_pkg::CHR_EQ, fqpp_pkg::KIND_DATA, 1'b1, 1'b1), z, z);
		push_item(fqpp_pkg::CHR_PCT, 1'b0);
		push_item(fqpp_pkg::CHR_ZERO, 1'b0);
		push_typed(fqpp_pkg::CHR_AMP, 1'b0, 3,
			mk_res(fqpp_pkg::CHR_PCT, fqpp_pkg::KIND_DATA, 1'b1, 1'b0),
			mk_res(fqpp_pkg::CHR_ZERO, fqpp_pkg::KIND_DATA, 1'b1, 1'b0),
			mk_res(8'h00, fqpp_pkg::KIND_PAIR_END, 1'b1, 1'b1));
		push_typed(8'hFF, 1'b0, 1, mk_res(8'hFF, fqpp_pkg::KIND_DATA, 1'b0, 1'b1), z, z);
		push_typed(8'h01, 1'b0, 1, mk_res(8'h01, fqpp_pkg::KIND_DATA, 1'b0, 1'b1), z, z);
		push_item(fqpp_pkg::CHR_PCT, 1'b0);
		push_typed(fqpp_pkg::CHR_EQ, 1'b0, 2,
			mk_res(fqpp_pkg::CHR_PCT, fqpp_pkg::KIND_DATA, 1'b0, 1'b0),
			mk_res(8'h00, fqpp_pkg::KIND_NAME_END, 1'b0, 1'b1), z);
		push_item(fqpp_pkg::CHR_PCT, 1'b0);
		push_item(fqpp_pkg::CHR_PCT, 1'b0);
		push_item(fqpp_pkg::CHR_PCT, 1'b0);
		push_item(fqpp_pkg::CHR_PCT, 1'b0);
		push_item(8'h80, 1'b0);
		push_item(8'hFF, 1'b0);
		push_typed(8'hA5, 1'b1, 1,
			mk_res(8'h00, fqpp_pkg::KIND_INPUT_END, 1'b1, 1'b1), z, z);
		push_item(fqpp_pkg::CHR_PCT, 1'b0);
		push_typed(8'h5A, 1'b1, 2,
			mk_res(fqpp_pkg::CHR_PCT, fqpp_pkg::KIND_DATA, 1'b0, 1'b0),
			mk_res(8'h00, fqpp_pkg::KIND_INPUT_END, 1'b0, 1'b1), z);
		push_typed(fqpp_pkg::CHR_AMP, 1'b0, 1,
			mk_res(8'h00, fqpp_pkg::KIND_PAIR_END, 1'b0, 1'b1), z, z);
		n_dir = stim_q.size();

		while (stim_q.size() < 225) begin
			repeat ($urandom_range(0, 4)) push_token();
			if ($urandom_range(0, 99) < 85) begin
				push_item(fqpp_pkg::CHR_EQ, 1'b0);
				repeat ($urandom_range(0, 5)) push_token();
			end
			if ($urandom_range(0, 99) < 80) begin
				push_item(fqpp_pkg::CHR_AMP, 1'b0);
			end else begin
				push_item(8'($urandom_range(0, 255)), 1'b1);
			end
		end
		push_item(8'($urandom_range(0, 255)), 1'b1);
		total = stim_q.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int idx = 0; idx < total; idx++) begin
			it = stim_q[idx];
			calm = (idx >= total - 40);
			if (!calm && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			if (idx == n_dir + 40) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_res.size() != 0);
			end
			if (idx == n_dir + 110) begin
				hold_req = 1'b1;
			end
			in_valid <= 1'b1;
			data_byte <= it.ch;
			is_end <= it.fin;
			do @(posedge clk); while (!in_ready);
			n_items++;
			decode_item(it.ch, it.fin);
			if (it.typed) begin
				if (it.n > 0) pending_res.push_back(it.t0);
				if (it.n > 1) pending_res.push_back(it.t1);
				if (it.n > 2) pending_res.push_back(it.t2);
			end else begin
				foreach (step_res[k]) pending_res.push_back(step_res[k]);
			end
		end
		in_valid <= 1'b0;

		while (pending_res.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		bad += pending_res.size();

		$display("run: %0d items sent, %0d results checked, %0d input stall cycles",
			n_items, n_results, n_in_stall);
		$display("mix: names, values, hex escapes, broken escapes, markers, random bytes");
		if (bad == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
